>>> hdl/uomap_pkg.sv
// Shared types, constants and decode functions of the UTF-8/UTF-16 offset mapper.
package uomap_pkg;

    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int OFS_W    = 13;
    localparam int UNIT_W   = OFS_W + 1;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [BYTE_W-1:0] CONT_LO = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_HI = 8'hBF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QCHK,
        S_LOOP,
        S_LEAD,
        S_CONT,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_CURSOR,
        RES_START
    } res_src_t;

    typedef enum logic [1:0] {
        LEAD_ASCII,
        LEAD_MULTI,
        LEAD_BAD
    } lead_kind_t;

    typedef struct packed {
        logic     clear;
        logic     append;
        logic     latch_target;
        logic     issue_lead;
        logic     lead_accept;
        logic     ascii_commit;
        logic     cont_next;
        logic     cp_commit;
        logic     invalidate;
        logic     res_load;
        logic     res_status;
        res_src_t res_src;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] in_op;
        logic            store_full;
        logic            invalid;
        logic            target_behind;
        logic            walk_more;
        logic            at_target;
        lead_kind_t      lead_kind;
        logic            too_short;
        logic            cont_ok;
        logic            cont_last;
        logic            pair_split;
        logic            out_free;
    } dp_stat_t;

    // Sequence length from the lead byte; zero marks an illegal lead.
    function automatic logic [2:0] lead_len(input logic [BYTE_W-1:0] b);
        logic [2:0] n;
        n = 3'd0;
        if (b < 8'h80) begin
            n = 3'd1;
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
            n = 3'd2;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
            n = 3'd3;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
            n = 3'd4;
        end
        return n;
    endfunction

    // Narrowed range of the first continuation byte (overlong and surrogate guards).
    function automatic logic [BYTE_W-1:0] lead_lo(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] v;
        v = CONT_LO;
        if (b == 8'hE0) begin
            v = 8'hA0;
        end else if (b == 8'hF0) begin
            v = 8'h90;
        end
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] lead_hi(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] v;
        v = CONT_HI;
        if (b == 8'hED) begin
            v = 8'h9F;
        end else if (b == 8'hF4) begin
            v = 8'h8F;
        end
        return v;
    endfunction

endpackage

>>> hdl/uomap_ctrl.sv
// Controller state machine of the offset mapper: sequences appends, clears and the query walk.
module uomap_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  uomap_pkg::dp_stat_t   stat,
    output uomap_pkg::ctrl_cmd_t  cmd
);
    import uomap_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (stat.in_op == OP_QUERY) begin
                        state_next = S_QCHK;
                    end else begin
                        state_next = S_RESP;
                    end
                end
            end
            S_QCHK: begin
                if (stat.invalid || stat.target_behind) begin
                    state_next = S_RESP;
                end else begin
                    state_next = S_LOOP;
                end
            end
            S_LOOP: begin
                if (stat.walk_more) begin
                    state_next = S_LEAD;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_LEAD: begin
                unique case (stat.lead_kind)
                    LEAD_ASCII: state_next = S_LOOP;
                    LEAD_MULTI: state_next = stat.too_short ? S_RESP : S_CONT;
                    default:    state_next = S_RESP;
                endcase
            end
            S_CONT: begin
                priority if (!stat.cont_ok) begin
                    state_next = S_RESP;
                end else if (stat.cont_last) begin
                    state_next = stat.pair_split ? S_RESP : S_LOOP;
                end else begin
                    state_next = S_CONT;
                end
            end
            S_RESP: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.res_src = RES_ZERO;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    unique case (stat.in_op)
                        OP_CLEAR: begin
                            cmd.clear    = 1'b1;
                            cmd.res_load = 1'b1;
                        end
                        OP_APPEND: begin
                            cmd.res_load = 1'b1;
                            if (stat.store_full) begin
                                cmd.invalidate = 1'b1;
                                cmd.res_status = 1'b1;
                            end else begin
                                cmd.append = 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            cmd.latch_target = 1'b1;
                        end
                        default: begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = 1'b1;
                        end
                    endcase
                end
            end
            S_QCHK: begin
                if (stat.invalid || stat.target_behind) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = 1'b1;
                end
            end
            S_LOOP: begin
                priority if (stat.walk_more) begin
                    cmd.issue_lead = 1'b1;
                end else if (stat.at_target) begin
                    cmd.res_load = 1'b1;
                    cmd.res_src  = RES_CURSOR;
                end else begin
                    cmd.invalidate = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = 1'b1;
                end
            end
            S_LEAD: begin
                if (stat.lead_kind == LEAD_ASCII) begin
                    cmd.ascii_commit = 1'b1;
                end else if (stat.lead_kind == LEAD_MULTI && !stat.too_short) begin
                    cmd.lead_accept = 1'b1;
                end else begin
                    cmd.invalidate = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = 1'b1;
                end
            end
            S_CONT: begin
                priority if (!stat.cont_ok) begin
                    cmd.invalidate = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = 1'b1;
                end else if (stat.cont_last) begin
                    cmd.cp_commit = 1'b1;
                    if (stat.pair_split) begin
                        cmd.res_load = 1'b1;
                        cmd.res_src  = RES_START;
                    end
                end else begin
                    cmd.cont_next = 1'b1;
                end
            end
            S_RESP: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
                cmd.res_src = RES_ZERO;
            end
        endcase
    end

endmodule

>>> hdl/uomap_dp.sv
// Datapath of the offset mapper: text memory, cursors, decode checks and the result register.
module uomap_dp #(
    parameter int TEXT_BYTES = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [uomap_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [uomap_pkg::M_DATA_W-1:0]  m_tdata,
    input  uomap_pkg::ctrl_cmd_t            cmd,
    output uomap_pkg::dp_stat_t             stat
);
    import uomap_pkg::*;

    localparam int LEN_W = $clog2(TEXT_BYTES + 1);
    localparam int AW    = $clog2(TEXT_BYTES);

    logic [BYTE_W-1:0] mem [TEXT_BYTES];

    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  byte_cur_reg;
    logic [UNIT_W-1:0] unit_cur_reg;
    logic              valid_reg;
    logic [OFS_W-1:0]  target_reg;
    logic [LEN_W-1:0]  start_reg;
    logic [2:0]        count_reg;
    logic [1:0]        k_reg;
    logic [BYTE_W-1:0] lo_reg;
    logic [BYTE_W-1:0] hi_reg;
    logic [BYTE_W-1:0] rdata_reg;
    logic              res_status_reg;
    logic [OFS_W-1:0]  res_ofs_reg;
    logic              out_valid_reg;
    logic              out_status_reg;
    logic [OFS_W-1:0]  out_ofs_reg;

    logic [OP_W-1:0]   in_op;
    logic [BYTE_W-1:0] in_byte;
    logic [OFS_W-1:0]  in_target;
    logic [UNIT_W-1:0] target_ext;
    logic [1:0]        k_next;
    logic [LEN_W-1:0]  rd_sum;
    logic              rd_en;
    logic [2:0]        lead_count;
    logic [BYTE_W-1:0] lo_sel;
    logic [BYTE_W-1:0] hi_sel;
    logic [1:0]        units;
    logic [UNIT_W-1:0] unit_sum;
    logic [LEN_W+OFS_W-1:0] cur_ext;
    logic [LEN_W+OFS_W-1:0] start_ext;
    logic [OFS_W-1:0]  res_ofs_next;

    assign in_op     = s_tdata[OP_W-1:0];
    assign in_byte   = s_tdata[OP_W+BYTE_W-1:OP_W];
    assign in_target = s_tdata[OP_W+BYTE_W+OFS_W-1:OP_W+BYTE_W];

    assign target_ext = {1'b0, target_reg};
    assign k_next     = cmd.lead_accept ? 2'd1 : k_reg + 2'd1;
    assign rd_sum     = cmd.issue_lead ? byte_cur_reg : start_reg + LEN_W'(k_next);
    assign rd_en      = cmd.issue_lead | cmd.lead_accept | cmd.cont_next;
    assign lead_count = lead_len(rdata_reg);
    assign lo_sel     = (k_reg == 2'd1) ? lo_reg : CONT_LO;
    assign hi_sel     = (k_reg == 2'd1) ? hi_reg : CONT_HI;
    assign units      = (count_reg == 3'd4) ? 2'd2 : 2'd1;
    assign unit_sum   = unit_cur_reg + UNIT_W'(units);
    assign cur_ext    = {{OFS_W{1'b0}}, byte_cur_reg};
    assign start_ext  = {{OFS_W{1'b0}}, start_reg};

    always_comb begin
        unique case (cmd.res_src)
            RES_CURSOR: res_ofs_next = cur_ext[OFS_W-1:0];
            RES_START:  res_ofs_next = start_ext[OFS_W-1:0];
            default:    res_ofs_next = '0;
        endcase
    end

    always_comb begin
        stat.in_op         = in_op;
        stat.store_full    = (len_reg >= LEN_W'(TEXT_BYTES));
        stat.invalid       = !valid_reg;
        stat.target_behind = (target_ext < unit_cur_reg);
        stat.walk_more     = (unit_cur_reg < target_ext) && (byte_cur_reg < len_reg);
        stat.at_target     = (unit_cur_reg == target_ext);
        if (lead_count == 3'd1) begin
            stat.lead_kind = LEAD_ASCII;
        end else if (lead_count == 3'd0) begin
            stat.lead_kind = LEAD_BAD;
        end else begin
            stat.lead_kind = LEAD_MULTI;
        end
        stat.too_short  = ((len_reg - byte_cur_reg) < LEN_W'(lead_count));
        stat.cont_ok    = (rdata_reg >= lo_sel) && (rdata_reg <= hi_sel);
        stat.cont_last  = ({1'b0, k_reg} == count_reg - 3'd1);
        stat.pair_split = (target_ext < unit_sum);
        stat.out_free   = !out_valid_reg || m_tready;
    end

    // Text memory: one write port at the fill level, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.append) begin
            mem[len_reg[AW-1:0]] <= in_byte;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_sum[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            byte_cur_reg  <= '0;
            unit_cur_reg  <= '0;
            valid_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                len_reg      <= '0;
                byte_cur_reg <= '0;
                unit_cur_reg <= '0;
                valid_reg    <= 1'b1;
            end
            if (cmd.append) begin
                len_reg <= len_reg + LEN_W'(1);
            end
            if (cmd.invalidate) begin
                valid_reg <= 1'b0;
            end
            if (cmd.ascii_commit) begin
                byte_cur_reg <= byte_cur_reg + LEN_W'(1);
                unit_cur_reg <= unit_cur_reg + UNIT_W'(1);
            end
            if (cmd.cp_commit) begin
                byte_cur_reg <= start_reg + LEN_W'(count_reg);
                unit_cur_reg <= unit_sum;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge aclk) begin
        if (cmd.latch_target) begin
            target_reg <= in_target;
        end
        if (cmd.issue_lead) begin
            start_reg <= byte_cur_reg;
        end
        if (cmd.lead_accept) begin
            count_reg <= lead_count;
            lo_reg    <= lead_lo(rdata_reg);
            hi_reg    <= lead_hi(rdata_reg);
        end
        if (cmd.lead_accept || cmd.cont_next) begin
            k_reg <= k_next;
        end
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_status;
            res_ofs_reg    <= res_ofs_next;
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_ofs_reg    <= res_ofs_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - OFS_W - 1){1'b0}}, out_ofs_reg, out_status_reg};

endmodule

>>> hdl/utf8_utf16_offset_mapper.sv
// Top level of the UTF-8 text store with UTF-16 to UTF-8 offset mapping.
//
//  Channel | Direction | tdata fields (lowest bit first)
//  --------+-----------+------------------------------------------------------
//  s_      | in        | opcode[1:0], text_byte[9:2], utf16_target[22:10], pad
//  m_      | out       | status[0], byte_offset[13:1], pad
//
// Clear and append go from idle to the response state, which waits for a free output
// register. A query checks the cursor, then walks a loop and a lead step per code
// point and a continuation step per further byte; the memory reads one byte a cycle.
// Cursors only advance, so no query walks bytes already walked since a clear.
// Reset (aresetn low, synchronous) empties the text and drops any pending result.
// A stalled result holds the next transaction, once walked, with s_tready low.
module utf8_utf16_offset_mapper #(
    parameter int TEXT_BYTES = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // opcode[1:0], text_byte[9:2], utf16_target[22:10], zero pad[23]
    input  logic [uomap_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[0], byte_offset[13:1], zero pad[15:14]
    output logic [uomap_pkg::M_DATA_W-1:0]  m_tdata
);
    import uomap_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Sequence each transaction and the code point walk.
    uomap_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the text, the cursors and the result register.
    uomap_dp #(
        .TEXT_BYTES (TEXT_BYTES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
